@@ src/tlbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, derived widths and the update bundles used by the page
// translator submodules.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	// table sizes
	localparam int TLB_ENTRIES  = 16;
	localparam int PAGE_COUNT   = 256;
	localparam int FRAME_COUNT  = 128;
	localparam int OFFSET_WIDTH = 8;

	// fixed field widths
	localparam int LA_W = 16;
	localparam int PA_W = 15;

	// derived widths
	localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
	localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

	// tlb update: install at the fill slot, drop every entry of an evicted page
	typedef struct packed {
		logic               install;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic               drop;
		logic [PAGE_W-1:0]  drop_page;
	} tlbpt_tlb_upd_t;

	// page table update: map a faulting page, unmap the evicted one
	typedef struct packed {
		logic               map_en;
		logic [PAGE_W-1:0]  map_page;
		logic [FRAME_W-1:0] map_frame;
		logic               unmap_en;
		logic [PAGE_W-1:0]  unmap_page;
	} tlbpt_pt_upd_t;

endpackage

@@ src/tlbpt_tlb.sv @@
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB in flops with FIFO fill; lowest matching entry wins.
// ----------------------------------------------------------------------------
module tlbpt_tlb import tlbpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PAGE_W-1:0]  lookup_page,
	output logic               hit,
	output logic [FRAME_W-1:0] hit_frame,
	input  tlbpt_tlb_upd_t     upd
);

	logic [TLB_ENTRIES-1:0] valid_q;
	logic [PAGE_W-1:0]      page_q  [TLB_ENTRIES];
	logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
	logic [TLB_IDX_W-1:0]   fill_q;

	// parallel compare, lowest index has priority
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == lookup_page) begin
				hit       = 1'b1;
				hit_frame = frame_q[i];
			end
		end
	end

	// valid bits: install wins over drop on the fill slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (upd.install && fill_q == TLB_IDX_W'(i)) begin
					valid_q[i] <= 1'b1;
				end else if (upd.drop && valid_q[i] && page_q[i] == upd.drop_page) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (upd.install && fill_q == TLB_IDX_W'(i)) begin
				page_q[i]  <= upd.page;
				frame_q[i] <= upd.frame;
			end
		end
	end

	// fifo fill pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (upd.install) begin
			fill_q <= (fill_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : fill_q + 1'b1;
		end
	end

endmodule

@@ src/tlbpt_page_table.sv @@
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page table: valid bits in flops, frame numbers in a single-port RAM with
// a registered read.
// ----------------------------------------------------------------------------
module tlbpt_page_table import tlbpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [PAGE_W-1:0]  rd_page,
	output logic [FRAME_W-1:0] rd_frame,
	input  logic [PAGE_W-1:0]  lookup_page,
	output logic               lookup_valid,
	input  tlbpt_pt_upd_t      upd
);

	logic [PAGE_COUNT-1:0] map_valid_q;
	logic [FRAME_W-1:0]    map_frame_mem [PAGE_COUNT];
	logic [FRAME_W-1:0]    rd_frame_q;

	assign lookup_valid = map_valid_q[lookup_page];
	assign rd_frame     = rd_frame_q;

	// valid bits: unmap the evicted page, then map the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
		end else begin
			if (upd.unmap_en) begin
				map_valid_q[upd.unmap_page] <= 1'b0;
			end
			if (upd.map_en) begin
				map_valid_q[upd.map_page] <= 1'b1;
			end
		end
	end

	// frame ram, read and write never in the same cycle
	always_ff @(posedge clk) begin
		if (upd.map_en) begin
			map_frame_mem[upd.map_page] <= upd.map_frame;
		end else if (rd_en) begin
			rd_frame_q <= map_frame_mem[rd_page];
		end
	end

endmodule

@@ src/tlbpt_frame_table.sv @@
// ----------------------------------------------------------------------------
// tlbpt_frame_table
// Frame ownership: owner valid bits in flops, owner pages in a single-port
// RAM, and the FIFO replacement pointer.
// ----------------------------------------------------------------------------
module tlbpt_frame_table import tlbpt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic               alloc_en,
	input  logic [PAGE_W-1:0]  alloc_page,
	output logic [FRAME_W-1:0] victim_frame,
	output logic               victim_valid,
	output logic [PAGE_W-1:0]  victim_page
);

	logic [FRAME_COUNT-1:0] owner_valid_q;
	logic [PAGE_W-1:0]      owner_page_mem [FRAME_COUNT];
	logic [PAGE_W-1:0]      owner_page_q;
	logic [FRAME_W-1:0]     fill_q;

	assign victim_frame = fill_q;
	assign victim_valid = owner_valid_q[fill_q];
	assign victim_page  = owner_page_q;

	// owner valid bits and fifo pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_valid_q <= '0;
			fill_q        <= '0;
		end else if (alloc_en) begin
			owner_valid_q[fill_q] <= 1'b1;
			fill_q <= (fill_q == FRAME_W'(FRAME_COUNT - 1)) ? '0 : fill_q + 1'b1;
		end
	end

	// owner page ram, read ahead at the current pointer
	always_ff @(posedge clk) begin
		if (alloc_en) begin
			owner_page_mem[fill_q] <= alloc_page;
		end else if (rd_en) begin
			owner_page_q <= owner_page_mem[fill_q];
		end
	end

endmodule

@@ src/tlb_page_table_translator_top.sv @@
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Demand-paging address translator with a FIFO-filled TLB and FIFO frame
// replacement.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid/in_stall   | vaddr
//   out     | output    | out_valid/out_stall | physical_address, tlb_hit,
//           |           |                     | page_fault
//
// The transfer cycle reads the page table RAM and the frame owner RAM ahead;
// the ST_LOOK state then resolves hit, miss or fault and writes all tables,
// and waits while a held result is stalled. The single-port RAMs set this split.
// Reset empties every table at once through valid bits, no clearing pass.
// A new item is taken while a result waits in the output register; a held
// result only stalls the resolve cycle of the following item.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top import tlbpt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [LA_W-1:0] vaddr,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [PA_W-1:0] physical_address,
	output logic            tlb_hit,
	output logic            page_fault
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic                    state_q;
	logic [PAGE_W-1:0]       page_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic                    out_valid_q;
	logic [PA_W-1:0]         pa_q;
	logic                    hit_q;
	logic                    fault_q;

	logic                    in_xfer;
	logic                    done;
	logic [PAGE_W-1:0]       in_page;
	logic                    tlb_match;
	logic [FRAME_W-1:0]      tlb_frame;
	logic                    pt_valid;
	logic [FRAME_W-1:0]      pt_frame;
	logic [FRAME_W-1:0]      victim_frame;
	logic                    victim_valid;
	logic [PAGE_W-1:0]       victim_page;
	logic                    fault;
	logic [FRAME_W-1:0]      frame;
	tlbpt_tlb_upd_t          tlb_upd;
	tlbpt_pt_upd_t           pt_upd;

	// handshake
	assign in_stall  = (state_q == ST_LOOK);
	assign in_xfer   = in_valid && !in_stall;
	assign done      = (state_q == ST_LOOK) && !(out_valid_q && out_stall);
	assign in_page   = PAGE_W'(vaddr >> OFFSET_WIDTH);
	assign out_valid = out_valid_q;
	assign physical_address = pa_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;

	// resolve: tlb, then page table, else take the next frame
	assign fault = !tlb_match && !pt_valid;
	always_comb begin
		if (tlb_match) begin
			frame = tlb_frame;
		end else if (pt_valid) begin
			frame = pt_frame;
		end else begin
			frame = victim_frame;
		end
	end

	// table updates in the resolve cycle
	always_comb begin
		tlb_upd.install   = done && !tlb_match;
		tlb_upd.page      = page_q;
		tlb_upd.frame     = frame;
		tlb_upd.drop      = done && fault && victim_valid;
		tlb_upd.drop_page = victim_page;
		pt_upd.map_en     = done && fault;
		pt_upd.map_page   = page_q;
		pt_upd.map_frame  = victim_frame;
		pt_upd.unmap_en   = done && fault && victim_valid;
		pt_upd.unmap_page = victim_page;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			page_q   <= in_page;
			offset_q <= vaddr[OFFSET_WIDTH-1:0];
		end
		if (done) begin
			pa_q    <= PA_W'({frame, offset_q});
			hit_q   <= tlb_match;
			fault_q <= fault;
		end
	end

	tlbpt_tlb u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (page_q),
		.hit         (tlb_match),
		.hit_frame   (tlb_frame),
		.upd         (tlb_upd)
	);

	tlbpt_page_table u_page_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (in_xfer),
		.rd_page      (in_page),
		.rd_frame     (pt_frame),
		.lookup_page  (page_q),
		.lookup_valid (pt_valid),
		.upd          (pt_upd)
	);

	tlbpt_frame_table u_frame_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_en        (in_xfer),
		.alloc_en     (done && fault),
		.alloc_page   (page_q),
		.victim_frame (victim_frame),
		.victim_valid (victim_valid),
		.victim_page  (victim_page)
	);

endmodule
